[src/least_squares_line_fit_defines.svh]
// Assertion macros used by the checker file of the line-fit block.
`ifndef LEAST_SQUARES_LINE_FIT_DEFINES_SVH
`define LEAST_SQUARES_LINE_FIT_DEFINES_SVH

// Same-cycle implication, sampled on clk and ignored while arst_n is low.
`define LSLF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and ignored while arst_n is low.
`define LSLF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

[src/lslf_pkg.sv]
// Shared widths, codes and unit command types of the line-fit block.
`default_nettype none

package lslf_pkg;

	// Largest number of points kept in one data set.
	localparam int MAX_POINTS = 1024;

	localparam int PT_W    = 16;  // x and y samples
	localparam int CNT_W   = 11;  // point counter
	localparam int SX_W    = 27;  // sum of x and sum of y
	localparam int SXX_W   = 41;  // sum of x squared
	localparam int SXY_W   = 42;  // sum of x times y
	localparam int VXX_W   = 51;  // n*Sxx - Sx*Sx, never negative
	localparam int ACC_W   = 68;  // accumulator, holds Sxx*Sy - Sx*Sxy
	localparam int FRAC_SH = 16;  // fraction bits added before dividing
	localparam int NUM_W   = ACC_W + FRAC_SH;
	localparam int QUO_W   = 49;  // quotient bits kept, higher ones are sticky
	localparam int DCNT_W  = $clog2(NUM_W);
	localparam int SLOPE_W = 32;
	localparam int ICEPT_W = 48;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_NOPTS = 2'd1,
		STAT_ZVAR  = 2'd2,
		STAT_OVFL  = 2'd3
	} fit_status_t;

	typedef enum logic {
		OP_MUL = 1'b0,
		OP_DIV = 1'b1
	} alu_op_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
		logic    keep;    // multiply: add onto the current accumulator
		logic    negate;  // multiply: subtract the product instead
	} alu_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} alu_rsp_t;

endpackage

`default_nettype wire

[src/least_squares_line_fit.sv]
// Top level of the streaming least-squares line fit: sums, sequencer and result beat.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------------------
//   pt      | in        | pt_valid / pt_stall  | x_value, y_value, has_point, last
//   fit     | out       | fit_valid / fit_stall| slope, intercept, status, points_used
//
// An input beat without a point and without last is taken and leaves the block idle.
// A beat with a kept point sends x*x and x*y each through the shared shift-add unit,
// one multiplier bit per cycle.
// A beat with last then runs up to six wide products and two 84-step divisions on that
// same unit; pt_stall stays high for the whole time.
// The result beat sits in an output register, so a stalled fit channel only holds the
// block once the next fit is ready to be written. Reset clears all sums at once.
`default_nettype none

module least_squares_line_fit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 pt_valid,
	output logic                                 pt_stall,
	input  logic signed [lslf_pkg::PT_W-1:0]     x_value,
	input  logic signed [lslf_pkg::PT_W-1:0]     y_value,
	input  logic                                 has_point,
	input  logic                                 last,
	output logic                                 fit_valid,
	input  logic                                 fit_stall,
	output logic signed [lslf_pkg::SLOPE_W-1:0]  slope,
	output logic signed [lslf_pkg::ICEPT_W-1:0]  intercept,
	output logic        [1:0]                    status,
	output logic        [lslf_pkg::CNT_W-1:0]    points_used
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_RUN  = 2'b10
	} state_t;

	// Steps of the sequencer; each one except the emit step is one unit operation.
	typedef enum logic [10:0] {
		STP_XX    = 11'b000_0000_0001,
		STP_XY    = 11'b000_0000_0010,
		STP_VXX_A = 11'b000_0000_0100,
		STP_VXX_B = 11'b000_0000_1000,
		STP_VXY_A = 11'b000_0001_0000,
		STP_VXY_B = 11'b000_0010_0000,
		STP_DIV_S = 11'b000_0100_0000,
		STP_BN_A  = 11'b000_1000_0000,
		STP_BN_B  = 11'b001_0000_0000,
		STP_DIV_I = 11'b010_0000_0000,
		STP_EMIT  = 11'b100_0000_0000
	} step_t;

	localparam int AW = lslf_pkg::ACC_W;

	state_t                                 state_q;
	step_t                                  step_q;
	logic                                   issued_q;
	logic        [lslf_pkg::CNT_W-1:0]      count_q;
	logic signed [lslf_pkg::SX_W-1:0]       sum_x_q;
	logic signed [lslf_pkg::SX_W-1:0]       sum_y_q;
	logic signed [lslf_pkg::SXX_W-1:0]      sum_xx_q;
	logic signed [lslf_pkg::SXY_W-1:0]      sum_xy_q;
	logic                                   ovf_q;
	logic                                   last_q;
	logic signed [lslf_pkg::PT_W-1:0]       x_q;
	logic signed [lslf_pkg::PT_W-1:0]       y_q;
	logic        [lslf_pkg::VXX_W-1:0]      vxx_q;
	logic        [lslf_pkg::SLOPE_W-1:0]    slope_res_q;
	lslf_pkg::fit_status_t                  stat_q;

	logic                                   fit_valid_q;
	logic signed [lslf_pkg::SLOPE_W-1:0]    slope_q;
	logic signed [lslf_pkg::ICEPT_W-1:0]    intercept_q;
	logic        [1:0]                      status_q;
	logic        [lslf_pkg::CNT_W-1:0]      points_q;

	lslf_pkg::alu_cmd_t                     alu_cmd;
	lslf_pkg::alu_rsp_t                     alu_rsp;
	logic signed [AW-1:0]                   alu_opa;
	logic signed [AW-1:0]                   alu_opb;
	logic signed [AW-1:0]                   alu_acc;
	logic        [lslf_pkg::QUO_W-1:0]      alu_quot;
	logic                                   alu_big;
	logic                                   alu_neg;

	logic                                   pt_take;
	logic                                   keep_pt;
	logic                                   emit_go;
	logic        [lslf_pkg::ICEPT_W-1:0]    slope_sat;
	logic        [lslf_pkg::ICEPT_W-1:0]    icept_sat;

	// Truncated quotient magnitude to a saturated signed field of SLOPE_W or ICEPT_W bits.
	function automatic logic [lslf_pkg::ICEPT_W-1:0] sat_quot(
		input logic [lslf_pkg::QUO_W-1:0] q,
		input logic                       big,
		input logic                       neg,
		input logic                       wide
	);
		logic [lslf_pkg::QUO_W-1:0] lim;
		logic [lslf_pkg::QUO_W-1:0] mag;
		logic [lslf_pkg::QUO_W-1:0] res;
		lim = wide ? (lslf_pkg::QUO_W'(1) << (lslf_pkg::ICEPT_W - 1))
		           : (lslf_pkg::QUO_W'(1) << (lslf_pkg::SLOPE_W - 1));
		if (neg) begin
			mag = (big || (q > lim)) ? lim : q;
			res = ~mag + lslf_pkg::QUO_W'(1);
		end else begin
			mag = (big || (q >= lim)) ? (lim - lslf_pkg::QUO_W'(1)) : q;
			res = mag;
		end
		return res[lslf_pkg::ICEPT_W-1:0];
	endfunction

	lslf_alu u_alu (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (alu_cmd),
		.opa      (alu_opa),
		.opb      (alu_opb),
		.rsp      (alu_rsp),
		.acc      (alu_acc),
		.quot     (alu_quot),
		.quot_big (alu_big),
		.quot_neg (alu_neg)
	);

	assign pt_stall = (state_q != S_IDLE);
	assign pt_take  = pt_valid && !pt_stall;
	assign keep_pt  = has_point && (count_q < lslf_pkg::CNT_W'(lslf_pkg::MAX_POINTS));

	// The fit may be written once the output register is free or being emptied.
	assign emit_go = (state_q == S_RUN) && (step_q == STP_EMIT) && (!fit_valid_q || !fit_stall);

	assign slope_sat = sat_quot(alu_quot, alu_big, alu_neg, 1'b0);
	assign icept_sat = sat_quot(alu_quot, alu_big, alu_neg, 1'b1);

	// Operand selection for the step in progress. Variances and numerators are built as
	// a product followed by a subtracted product on the same accumulator.
	always_comb begin
		alu_opa     = '0;
		alu_opb     = '0;
		alu_cmd     = '0;
		alu_cmd.op  = lslf_pkg::OP_MUL;
		case (step_q)
			STP_XX: begin
				alu_opa = {{(AW - lslf_pkg::PT_W){x_q[lslf_pkg::PT_W-1]}}, x_q};
				alu_opb = {{(AW - lslf_pkg::PT_W){x_q[lslf_pkg::PT_W-1]}}, x_q};
			end
			STP_XY: begin
				alu_opa = {{(AW - lslf_pkg::PT_W){x_q[lslf_pkg::PT_W-1]}}, x_q};
				alu_opb = {{(AW - lslf_pkg::PT_W){y_q[lslf_pkg::PT_W-1]}}, y_q};
			end
			STP_VXX_A: begin
				alu_opa = {{(AW - lslf_pkg::SXX_W){sum_xx_q[lslf_pkg::SXX_W-1]}}, sum_xx_q};
				alu_opb = {{(AW - lslf_pkg::CNT_W){1'b0}}, count_q};
			end
			STP_VXX_B: begin
				alu_opa = {{(AW - lslf_pkg::SX_W){sum_x_q[lslf_pkg::SX_W-1]}}, sum_x_q};
				alu_opb = {{(AW - lslf_pkg::SX_W){sum_x_q[lslf_pkg::SX_W-1]}}, sum_x_q};
				alu_cmd.keep   = 1'b1;
				alu_cmd.negate = 1'b1;
			end
			STP_VXY_A: begin
				alu_opa = {{(AW - lslf_pkg::SXY_W){sum_xy_q[lslf_pkg::SXY_W-1]}}, sum_xy_q};
				alu_opb = {{(AW - lslf_pkg::CNT_W){1'b0}}, count_q};
			end
			STP_VXY_B: begin
				alu_opa = {{(AW - lslf_pkg::SX_W){sum_y_q[lslf_pkg::SX_W-1]}}, sum_y_q};
				alu_opb = {{(AW - lslf_pkg::SX_W){sum_x_q[lslf_pkg::SX_W-1]}}, sum_x_q};
				alu_cmd.keep   = 1'b1;
				alu_cmd.negate = 1'b1;
			end
			STP_DIV_S, STP_DIV_I: begin
				// The numerator is still in the accumulator from the step before.
				alu_opa    = alu_acc;
				alu_opb    = {{(AW - lslf_pkg::VXX_W){1'b0}}, vxx_q};
				alu_cmd.op = lslf_pkg::OP_DIV;
			end
			STP_BN_A: begin
				alu_opa = {{(AW - lslf_pkg::SXX_W){sum_xx_q[lslf_pkg::SXX_W-1]}}, sum_xx_q};
				alu_opb = {{(AW - lslf_pkg::SX_W){sum_y_q[lslf_pkg::SX_W-1]}}, sum_y_q};
			end
			STP_BN_B: begin
				alu_opa = {{(AW - lslf_pkg::SXY_W){sum_xy_q[lslf_pkg::SXY_W-1]}}, sum_xy_q};
				alu_opb = {{(AW - lslf_pkg::SX_W){sum_x_q[lslf_pkg::SX_W-1]}}, sum_x_q};
				alu_cmd.keep   = 1'b1;
				alu_cmd.negate = 1'b1;
			end
			default: begin
				alu_opa = '0;
			end
		endcase
		alu_cmd.start = (state_q == S_RUN) && !issued_q && (step_q != STP_EMIT)
		                && !alu_rsp.busy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= STP_XX;
			issued_q    <= 1'b0;
			count_q     <= '0;
			sum_x_q     <= '0;
			sum_y_q     <= '0;
			sum_xx_q    <= '0;
			sum_xy_q    <= '0;
			ovf_q       <= 1'b0;
			last_q      <= 1'b0;
			fit_valid_q <= 1'b0;
		end else begin
			if (fit_valid_q && !fit_stall) begin
				fit_valid_q <= 1'b0;
			end

			if (alu_cmd.start) begin
				issued_q <= 1'b1;
			end

			case (state_q)
				S_IDLE: begin
					if (pt_take) begin
						if (keep_pt) begin
							count_q <= count_q + lslf_pkg::CNT_W'(1);
							sum_x_q <= sum_x_q + {{(lslf_pkg::SX_W - lslf_pkg::PT_W){
							           x_value[lslf_pkg::PT_W-1]}}, x_value};
							sum_y_q <= sum_y_q + {{(lslf_pkg::SX_W - lslf_pkg::PT_W){
							           y_value[lslf_pkg::PT_W-1]}}, y_value};
							x_q     <= x_value;
							y_q     <= y_value;
							last_q  <= last;
							state_q <= S_RUN;
							step_q  <= STP_XX;
						end else begin
							if (has_point) begin
								ovf_q <= 1'b1;
							end
							if (last) begin
								state_q <= S_RUN;
								if (count_q == '0) begin
									step_q      <= STP_EMIT;
									stat_q      <= lslf_pkg::STAT_NOPTS;
									slope_res_q <= '0;
								end else begin
									step_q <= STP_VXX_A;
								end
							end
						end
					end
				end
				S_RUN: begin
					if (alu_rsp.done && issued_q) begin
						issued_q <= 1'b0;
						case (step_q)
							STP_XX: begin
								sum_xx_q <= sum_xx_q + alu_acc[lslf_pkg::SXX_W-1:0];
								step_q   <= STP_XY;
							end
							STP_XY: begin
								sum_xy_q <= sum_xy_q + alu_acc[lslf_pkg::SXY_W-1:0];
								if (last_q) begin
									step_q <= STP_VXX_A;
								end else begin
									state_q <= S_IDLE;
								end
							end
							STP_VXX_A: begin
								step_q <= STP_VXX_B;
							end
							STP_VXX_B: begin
								vxx_q <= alu_acc[lslf_pkg::VXX_W-1:0];
								if (alu_acc == '0) begin
									// All kept points share one x: no line.
									stat_q      <= lslf_pkg::STAT_ZVAR;
									slope_res_q <= '0;
									step_q      <= STP_EMIT;
								end else begin
									step_q <= STP_VXY_A;
								end
							end
							STP_VXY_A: begin
								step_q <= STP_VXY_B;
							end
							STP_VXY_B: begin
								step_q <= STP_DIV_S;
							end
							STP_DIV_S: begin
								slope_res_q <= slope_sat[lslf_pkg::SLOPE_W-1:0];
								step_q      <= STP_BN_A;
							end
							STP_BN_A: begin
								step_q <= STP_BN_B;
							end
							STP_BN_B: begin
								step_q <= STP_DIV_I;
							end
							STP_DIV_I: begin
								stat_q <= ovf_q ? lslf_pkg::STAT_OVFL : lslf_pkg::STAT_OK;
								step_q <= STP_EMIT;
							end
							default: begin
								step_q <= STP_EMIT;
							end
						endcase
					end
					if (emit_go) begin
						fit_valid_q <= 1'b1;
						state_q     <= S_IDLE;
						step_q      <= STP_XX;
						count_q     <= '0;
						sum_x_q     <= '0;
						sum_y_q     <= '0;
						sum_xx_q    <= '0;
						sum_xy_q    <= '0;
						ovf_q       <= 1'b0;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Result payload; the intercept quotient is still held by the unit at emit time.
	always_ff @(posedge clk) begin
		if (emit_go) begin
			slope_q  <= slope_res_q;
			status_q <= stat_q;
			points_q <= count_q;
			if ((stat_q == lslf_pkg::STAT_OK) || (stat_q == lslf_pkg::STAT_OVFL)) begin
				intercept_q <= icept_sat;
			end else begin
				intercept_q <= '0;
			end
		end
	end

	assign fit_valid   = fit_valid_q;
	assign slope       = slope_q;
	assign intercept   = intercept_q;
	assign status      = status_q;
	assign points_used = points_q;

endmodule

`default_nettype wire

[src/lslf_alu.sv]
// Shared shift-add multiplier and restoring divider built around one adder.
`default_nettype none

module lslf_alu (
	input  logic                                clk,
	input  logic                                arst_n,
	input  lslf_pkg::alu_cmd_t                  cmd,
	input  logic signed [lslf_pkg::ACC_W-1:0]   opa,
	input  logic signed [lslf_pkg::ACC_W-1:0]   opb,
	output lslf_pkg::alu_rsp_t                  rsp,
	output logic signed [lslf_pkg::ACC_W-1:0]   acc,
	output logic        [lslf_pkg::QUO_W-1:0]   quot,
	output logic                                quot_big,
	output logic                                quot_neg
);

	logic signed [lslf_pkg::ACC_W-1:0]  acc_q;
	logic        [lslf_pkg::ACC_W-1:0]  mc_q;
	logic        [lslf_pkg::NUM_W-1:0]  mp_q;
	logic        [lslf_pkg::QUO_W-1:0]  q_q;
	logic                               qbig_q;
	logic                               neg_q;
	lslf_pkg::alu_op_t                  op_q;
	logic                               busy_q;
	logic                               done_q;
	logic        [lslf_pkg::DCNT_W-1:0] cnt_q;

	logic [lslf_pkg::ACC_W-1:0] mag_a;
	logic [lslf_pkg::ACC_W-1:0] mag_b;
	logic [lslf_pkg::ACC_W-1:0] rem_sh;
	logic [lslf_pkg::ACC_W-1:0] add_a;
	logic [lslf_pkg::ACC_W-1:0] add_b;
	logic [lslf_pkg::ACC_W-1:0] add_s;
	logic                       add_sub;

	assign mag_a = opa[lslf_pkg::ACC_W-1] ? ($unsigned(~opa) + lslf_pkg::ACC_W'(1))
	                                      : $unsigned(opa);
	assign mag_b = opb[lslf_pkg::ACC_W-1] ? ($unsigned(~opb) + lslf_pkg::ACC_W'(1))
	                                      : $unsigned(opb);

	// The divider shifts the next numerator bit into the partial remainder.
	assign rem_sh = {acc_q[lslf_pkg::ACC_W-2:0], mp_q[lslf_pkg::NUM_W-1]};

	always_comb begin
		if (op_q == lslf_pkg::OP_DIV) begin
			add_a   = rem_sh;
			add_b   = mc_q;
			add_sub = 1'b1;
		end else begin
			add_a   = $unsigned(acc_q);
			add_b   = mc_q;
			add_sub = neg_q;
		end
	end

	assign add_s = add_a + (add_sub ? ~add_b : add_b) + lslf_pkg::ACC_W'(add_sub);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q   <= lslf_pkg::OP_MUL;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (!busy_q) begin
				if (cmd.start) begin
					busy_q <= 1'b1;
					op_q   <= cmd.op;
					cnt_q  <= '0;
					q_q    <= '0;
					qbig_q <= 1'b0;
					if (cmd.op == lslf_pkg::OP_DIV) begin
						acc_q <= '0;
						mc_q  <= mag_b;
						mp_q  <= lslf_pkg::NUM_W'(mag_a) << lslf_pkg::FRAC_SH;
						neg_q <= opa[lslf_pkg::ACC_W-1] ^ opb[lslf_pkg::ACC_W-1];
					end else begin
						if (!cmd.keep) begin
							acc_q <= '0;
						end
						mc_q  <= mag_a;
						mp_q  <= lslf_pkg::NUM_W'(mag_b);
						neg_q <= opa[lslf_pkg::ACC_W-1] ^ opb[lslf_pkg::ACC_W-1] ^ cmd.negate;
					end
				end
			end else if (op_q == lslf_pkg::OP_DIV) begin
				// One quotient bit per cycle; bits above the kept window are sticky.
				mp_q   <= mp_q << 1;
				q_q    <= {q_q[lslf_pkg::QUO_W-2:0], ~add_s[lslf_pkg::ACC_W-1]};
				qbig_q <= qbig_q | q_q[lslf_pkg::QUO_W-1];
				acc_q  <= add_s[lslf_pkg::ACC_W-1] ? $signed(rem_sh) : $signed(add_s);
				cnt_q  <= cnt_q + lslf_pkg::DCNT_W'(1);
				if (cnt_q == lslf_pkg::DCNT_W'(lslf_pkg::NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else begin
				// Multiply stops as soon as no multiplier bits are left.
				if (mp_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					if (mp_q[0]) begin
						acc_q <= $signed(add_s);
					end
					mc_q <= mc_q << 1;
					mp_q <= mp_q >> 1;
				end
			end
		end
	end

	assign rsp      = '{busy: busy_q, done: done_q};
	assign acc      = acc_q;
	assign quot     = q_q;
	assign quot_big = qbig_q;
	assign quot_neg = neg_q;

endmodule

`default_nettype wire

[src/lslf_checker.sv]
// Port-level checks of the line-fit block and their binding to the top level.
`default_nettype none

`include "least_squares_line_fit_defines.svh"

module lslf_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 pt_valid,
	input logic                                 pt_stall,
	input logic signed [lslf_pkg::PT_W-1:0]     x_value,
	input logic signed [lslf_pkg::PT_W-1:0]     y_value,
	input logic                                 has_point,
	input logic                                 last,
	input logic                                 fit_valid,
	input logic                                 fit_stall,
	input logic signed [lslf_pkg::SLOPE_W-1:0]  slope,
	input logic signed [lslf_pkg::ICEPT_W-1:0]  intercept,
	input logic        [1:0]                    status,
	input logic        [lslf_pkg::CNT_W-1:0]    points_used
);

	// A held result beat keeps its payload.
	`LSLF_ASSERT_NEXT(a_fit_hold, fit_valid && fit_stall, fit_valid && $stable(slope) && $stable(intercept) && $stable(status) && $stable(points_used), "fit beat changed while stalled")

	// A taken beat that ends a data set always leaves the block busy with the fit.
	`LSLF_ASSERT_NEXT(a_last_busy, pt_valid && !pt_stall && last, pt_stall, "no busy cycle after a last beat")

	// An empty data set reports nothing but its status.
	`LSLF_ASSERT_NOW(a_nopts_zero, fit_valid && (status == lslf_pkg::STAT_NOPTS), (points_used == 0) && (slope == 0) && (intercept == 0), "empty fit with nonzero fields")

	// Without x spread there is no line.
	`LSLF_ASSERT_NOW(a_zvar_zero, fit_valid && (status == lslf_pkg::STAT_ZVAR), (slope == 0) && (intercept == 0), "zero-variance fit with nonzero line")

	// The kept point count never passes the limit.
	`LSLF_ASSERT_NOW(a_count_max, fit_valid, points_used <= lslf_pkg::CNT_W'(lslf_pkg::MAX_POINTS), "point count above limit")

endmodule

bind least_squares_line_fit lslf_checker u_lslf_checker (.*);

`default_nettype wire

[bench/testbench.sv]
// Self-checking testbench for the streaming least-squares line fit block.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import lslf_pkg::*;

	// A gap longer than this with no beat on either channel ends the run. The slowest
	// correct gap is the long receiver hold-off below plus one fit computation plus the
	// longest idle bursts on both sides.
	localparam int QUIET_LIMIT   = 6000;
	// Cycles the receiver holds off in the back-pressure test.
	localparam int PRESSURE_HOLD = 2000;
	// Cycles to wait after the last expected fit, a bit more than one full fit pass.
	localparam int DRAIN_CYCLES  = 400;

	// One fitted line as it appears on the output channel.
	typedef struct {
		logic signed [SLOPE_W-1:0] slope;
		logic signed [ICEPT_W-1:0] intercept;
		fit_status_t               status;
		logic [CNT_W-1:0]          points_used;
	} fit_t;

	logic clk;
	logic arst_n = 1'b0;

	logic                     pt_valid  = 1'b0;
	logic                     pt_stall;
	logic signed [PT_W-1:0]   x_value   = '0;
	logic signed [PT_W-1:0]   y_value   = '0;
	logic                     has_point = 1'b0;
	logic                     last      = 1'b0;
	logic                     fit_valid;
	logic                     fit_stall = 1'b0;
	logic signed [SLOPE_W-1:0] slope;
	logic signed [ICEPT_W-1:0] intercept;
	logic [1:0]               status;
	logic [CNT_W-1:0]         points_used;

	least_squares_line_fit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.pt_valid    (pt_valid),
		.pt_stall    (pt_stall),
		.x_value     (x_value),
		.y_value     (y_value),
		.has_point   (has_point),
		.last        (last),
		.fit_valid   (fit_valid),
		.fit_stall   (fit_stall),
		.slope       (slope),
		.intercept   (intercept),
		.status      (status),
		.points_used (points_used)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Running sums of the data set that is open right now, kept exact at 128 bits so
	// that no product or difference below can wrap.
	int                  kept_points = 0;
	logic signed [127:0] run_sx      = '0;
	logic signed [127:0] run_sy      = '0;
	logic signed [127:0] run_sxx     = '0;
	logic signed [127:0] run_sxy     = '0;
	bit                  points_dropped = 1'b0;

	// Fits predicted for beats already taken, oldest first.
	fit_t pending_fits[$];

	int  mismatches = 0;
	int  fits_seen  = 0;
	bit  idling     = 1'b0;
	int  hold_asks  = 0;
	int  hold_done  = 0;

	// Signed division rounds toward zero; the quotient is then clamped to w bits.
	function automatic logic signed [127:0] clamp_quotient(input logic signed [127:0] num,
			input logic signed [127:0] den, input int w);
		logic signed [127:0] q;
		logic signed [127:0] top;
		q   = num / den;
		top = (128'sd1 <<< (w - 1)) - 128'sd1;
		if (q > top)
			return top;
		if (q < -top - 128'sd1)
			return -top - 128'sd1;
		return q;
	endfunction

	// Folds one input beat into the running sums. When the beat closes the data set
	// it fills in the fitted line, clears the sums and returns 1.
	function automatic bit fit_model_step(input logic signed [PT_W-1:0] x,
			input logic signed [PT_W-1:0] y, input bit hp, input bit lst, output fit_t fit);
		logic signed [127:0] n_w;
		logic signed [127:0] var_x;
		logic signed [127:0] cov_xy;
		logic signed [127:0] icept_num;
		fit.slope       = '0;
		fit.intercept   = '0;
		fit.status      = STAT_OK;
		fit.points_used = '0;
		if (hp) begin
			if (kept_points < MAX_POINTS) begin
				kept_points++;
				run_sx  += x;
				run_sy  += y;
				run_sxx += x * x;
				run_sxy += x * y;
			end else begin
				points_dropped = 1'b1;
			end
		end
		if (!lst)
			return 1'b0;

		fit.points_used = CNT_W'(kept_points);
		if (kept_points == 0) begin
			fit.status = STAT_NOPTS;
		end else begin
			n_w   = kept_points;
			var_x = n_w * run_sxx - run_sx * run_sx;
			if (var_x == 0) begin
				fit.status = STAT_ZVAR;
			end else begin
				cov_xy    = n_w * run_sxy - run_sx * run_sy;
				icept_num = run_sxx * run_sy - run_sx * run_sxy;
				fit.slope     = SLOPE_W'(clamp_quotient(cov_xy <<< FRAC_SH, var_x, SLOPE_W));
				fit.intercept = ICEPT_W'(clamp_quotient(icept_num <<< FRAC_SH, var_x, ICEPT_W));
				fit.status    = points_dropped ? STAT_OVFL : STAT_OK;
			end
		end
		kept_points    = 0;
		run_sx         = '0;
		run_sy         = '0;
		run_sxx        = '0;
		run_sxy        = '0;
		points_dropped = 1'b0;
		return 1'b1;
	endfunction

	task automatic report_mismatch(input string what);
		$display("[%0t] fit #%0d: %s", $realtime, fits_seen, what);
		mismatches++;
	endtask

	// Offers one beat, optionally after an idle burst, and waits until it is taken.
	// pt_stall is read right after the edge, so it is the value that decided that edge.
	task automatic send_beat(input logic [PT_W-1:0] x, input logic [PT_W-1:0] y,
			input bit hp, input bit lst);
		fit_t fit;
		if (idling && $urandom_range(0, 5) == 0) begin
			pt_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		pt_valid  <= 1'b1;
		x_value   <= x;
		y_value   <= y;
		has_point <= hp;
		last      <= lst;
		do
			@(posedge clk);
		while (pt_stall);
		if (fit_model_step(x, y, hp, lst, fit))
			pending_fits.push_back(fit);
	endtask

	// Coordinate generators: full range, a small cluster around zero, values hugging
	// the two extremes, and a modest positive spread.
	function automatic logic [PT_W-1:0] pick_coord(input int flavor);
		case (flavor)
			0: return PT_W'($urandom);
			1: return PT_W'($urandom_range(0, 64)) - PT_W'(32);
			2: begin
				if ($urandom_range(0, 1))
					return 16'h7fff - PT_W'($urandom_range(0, 3));
				return 16'h8000 + PT_W'($urandom_range(0, 3));
			end
			default: return PT_W'($urandom_range(0, 4095));
		endcase
	endfunction

	// Beats with no point and no last must leave no trace; a bare last on an empty set
	// gives the no-points status.
	task automatic test_empty_sets();
		send_beat(16'h0000, 16'h0000, 1'b0, 1'b1);
		send_beat(16'h8000, 16'h7fff, 1'b0, 1'b0);
		send_beat(16'hffff, 16'h8000, 1'b0, 1'b1);
	endtask

	// One point, repeated x values and identical points all have zero x variance.
	task automatic test_degenerate_sets();
		send_beat(16'h1234, 16'hfedc, 1'b1, 1'b1);
		send_beat(16'h0040, 16'h0010, 1'b1, 1'b0);
		send_beat(16'h0040, 16'h8000, 1'b1, 1'b1);
		send_beat(16'hff00, 16'h0100, 1'b1, 1'b0);
		send_beat(16'hff00, 16'h0100, 1'b1, 1'b0);
		send_beat(16'h5555, 16'haaaa, 1'b0, 1'b1);
	endtask

	// A full y swing over one x step drives the slope past Q16.16 in both directions;
	// the four corners of the input range give large sums but an ordinary fit.
	task automatic test_saturation_extremes();
		send_beat(16'h0000, 16'h8000, 1'b1, 1'b0);
		send_beat(16'h0001, 16'h7fff, 1'b1, 1'b1);
		send_beat(16'h7ffe, 16'h7fff, 1'b1, 1'b0);
		send_beat(16'h7fff, 16'h8000, 1'b1, 1'b1);
		send_beat(16'h8000, 16'h8000, 1'b1, 1'b0);
		send_beat(16'h7fff, 16'h7fff, 1'b1, 1'b0);
		send_beat(16'h8000, 16'h7fff, 1'b1, 1'b0);
		send_beat(16'h7fff, 16'h8000, 1'b1, 1'b0);
		send_beat(16'h0000, 16'h0000, 1'b0, 1'b1);
	endtask

	// More points than the block keeps: the excess is dropped and flagged. A set whose
	// kept points all share one x reports zero variance instead of overflow.
	task automatic test_point_overflow();
		logic [PT_W-1:0] flat_x;
		int              flat;
		idling = 1'b1;
		for (flat = 0; flat < 2; flat++) begin
			flat_x = PT_W'($urandom);
			for (int i = 0; i < MAX_POINTS + 5; i++) begin
				if ($urandom_range(0, 31) == 0)
					send_beat(PT_W'($urandom), PT_W'($urandom), 1'b0, 1'b0);
				send_beat(flat ? flat_x : pick_coord(i % 4), PT_W'($urandom), 1'b1,
					i == MAX_POINTS + 4);
			end
		end
	endtask

	// Random data sets of mostly small size with random content; some are long, some
	// empty, some end on a bare last, and stray no-point beats are mixed in.
	task automatic test_random_sets(input int budget, input bit allow_idle);
		int              sent;
		int              npts;
		int              flavor;
		bit              close_on_point;
		logic [PT_W-1:0] flat_x;
		sent = 0;
		while (sent < budget) begin
			idling = allow_idle && ($urandom_range(0, 3) != 0);
			flavor = $urandom_range(0, 4);
			npts   = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
			flat_x = pick_coord(1);
			close_on_point = (npts > 0) && ($urandom_range(0, 1) == 1);
			for (int i = 0; i < npts; i++) begin
				if ($urandom_range(0, 7) == 0)
					send_beat(PT_W'($urandom), PT_W'($urandom), 1'b0, 1'b0);
				send_beat(flavor == 4 ? flat_x : pick_coord(flavor), pick_coord(flavor),
					1'b1, close_on_point && (i == npts - 1));
			end
			if (!close_on_point)
				send_beat(PT_W'($urandom), PT_W'($urandom), 1'b0, 1'b1);
			sent += npts + (close_on_point ? 0 : 1);
		end
	endtask

	// The receiver holds off for a long stretch while short sets keep coming, so the
	// output register fills, the next fit waits behind it and pt_stall backs up.
	task automatic test_backpressure();
		idling = 1'b0;
		hold_asks <= hold_asks + 1;
		for (int s = 0; s < 8; s++) begin
			send_beat(pick_coord(0), pick_coord(0), 1'b1, 1'b0);
			send_beat(pick_coord(0), pick_coord(0), 1'b1, 1'b1);
		end
	endtask

	// Receiver side: the requested long hold-off first, then random stall bursts.
	int stall_left = 0;
	int hold_left  = 0;
	always @(posedge clk) begin
		if (hold_asks != hold_done) begin
			hold_done <= hold_asks;
			hold_left <= PRESSURE_HOLD - 1;
			fit_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			fit_stall <= 1'b1;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			fit_stall  <= 1'b1;
		end else if (idling && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(1, 15) - 1;
			fit_stall  <= 1'b1;
		end else begin
			fit_stall <= 1'b0;
		end
	end

	// Every fit beat that is taken must match the oldest prediction in all its fields.
	always @(posedge clk) begin
		fit_t want;
		if (arst_n && fit_valid && !fit_stall) begin
			if (pending_fits.size() == 0) begin
				report_mismatch("fit beat arrived with no fit pending");
			end else begin
				want = pending_fits.pop_front();
				if (slope !== want.slope || intercept !== want.intercept ||
						status !== want.status || points_used !== want.points_used)
					report_mismatch($sformatf(
						"got slope %h icept %h status %0d pts %0d, want %h %h %0d %0d",
						slope, intercept, status, points_used, want.slope,
						want.intercept, want.status, want.points_used));
			end
			fits_seen++;
		end
	end

	// Watchdog: a long run of cycles with no beat on either channel means a hang.
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if (!arst_n || (pt_valid && !pt_stall) || (fit_valid && !fit_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The first directed tests run without idling; the rest mixes idle bursts and quiet
		// stretches, and the final part is quiet so the tail drains at full speed.
		test_empty_sets();
		test_degenerate_sets();
		test_saturation_extremes();
		test_point_overflow();
		test_random_sets(380, 1'b1);
		test_backpressure();
		test_random_sets(380, 1'b1);
		test_random_sets(40, 1'b0);
		idling = 1'b0;
		pt_valid <= 1'b0;

		while (pending_fits.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

[filelist.f]
+incdir+src
src/lslf_pkg.sv
src/lslf_alu.sv
src/least_squares_line_fit.sv
src/lslf_checker.sv
bench/testbench.sv
